[rtl/fir_pkg.sv]
package fir_pkg;

  localparam int TAPS     = 128;
  localparam int TAP_W    = $clog2(TAPS);
  localparam int CNT_W    = 8;
  localparam int SAMPLE_W = 8;
  localparam int CIDX_W   = 7;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int OUT_W    = 33;
  localparam int IN_DW    = 40;
  localparam int OUT_DW   = 40;

  localparam logic [CNT_W-1:0] TAPS_CNT      = CNT_W'(TAPS);
  localparam logic [CNT_W-1:0] TAP_COUNT_RST = 8'd128;
  localparam logic [CNT_W-1:0] FILL_MAX      = 8'hFF;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  typedef struct packed {
    logic                       hist_we;
    logic [TAP_W-1:0]           hist_waddr;
    logic signed [SAMPLE_W-1:0] hist_wdata;
    logic                       coef_we;
    logic [TAP_W-1:0]           coef_waddr;
    logic signed [COEF_W-1:0]   coef_wdata;
    logic [TAP_W-1:0]           hist_raddr;
    logic [TAP_W-1:0]           coef_raddr;
  } fir_mem_req_t;

  typedef struct packed {
    logic clr;
    logic valid;
    logic last;
  } fir_mac_ctl_t;

endpackage

[rtl/fir_tap_mem.sv]
module fir_tap_mem (
  input  logic                                clk,
  input  fir_pkg::fir_mem_req_t               req,
  output logic signed [fir_pkg::SAMPLE_W-1:0] hist_rd_r,
  output logic signed [fir_pkg::COEF_W-1:0]   coef_rd_r
);

  logic signed [fir_pkg::SAMPLE_W-1:0] hist_mem [fir_pkg::TAPS];
  logic signed [fir_pkg::COEF_W-1:0]   coef_mem [fir_pkg::TAPS];

  always_ff @(posedge clk) begin
    if (req.hist_we) begin
      hist_mem[req.hist_waddr] <= req.hist_wdata;
    end
    hist_rd_r <= hist_mem[req.hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.coef_we) begin
      coef_mem[req.coef_waddr] <= req.coef_wdata;
    end
    coef_rd_r <= coef_mem[req.coef_raddr];
  end

endmodule

[rtl/fir_mac.sv]
module fir_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fir_pkg::fir_mac_ctl_t               ctl,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] hist_d,
  input  logic signed [fir_pkg::COEF_W-1:0]   coef_d,
  output logic signed [fir_pkg::OUT_W-1:0]    acc_r,
  output logic                                done_r
);

  logic signed [fir_pkg::PROD_W-1:0] prod_r;
  logic                              prod_v_r;
  logic                              prod_last_r;
  logic signed [fir_pkg::OUT_W-1:0]  acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r    <= 1'b0;
      prod_last_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      prod_v_r    <= ctl.valid;
      prod_last_r <= ctl.valid & ctl.last;
      done_r      <= prod_v_r & prod_last_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= coef_d * hist_d;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + fir_pkg::OUT_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

[rtl/fir_filter_direct_form.sv]
// Channel  Dir  Request fields
// in_      in   tuser: action; tdata: sample, coef_index, coef_value
// out_     out  tdata: filtered
// cfg_     in   wr_data: tap_count
//
// Load and warm-up samples only write a tap memory and return to idle. A filtered sample
// reads tap_count taps (tap_count capped to 1..128): one tap per cycle through the single
// multiply-accumulate unit, fed by one read port on each tap memory.
// rst_n clears control, fill count and tap_count (128); tap memories are not cleared.
// A result waiting on out_ does not block the next request; a new result waits for it.
module fir_filter_direct_form (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [fir_pkg::IN_DW-1:0]  in_tdata,   // sample, coef_index, coef_value
  input  logic                       in_tuser,   // action
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [fir_pkg::OUT_DW-1:0] out_tdata,  // filtered
  input  logic                       cfg_wr_en,
  input  logic [fir_pkg::CNT_W-1:0]  cfg_wr_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam int SMP_LO  = 0;
  localparam int CIDX_LO = SMP_LO + fir_pkg::SAMPLE_W;
  localparam int COEF_LO = CIDX_LO + fir_pkg::CIDX_W;

  logic [1:0]                 state_r, state_nxt;
  logic [fir_pkg::TAP_W-1:0]  k_r, k_nxt;
  logic [fir_pkg::TAP_W-1:0]  base_r, base_nxt;
  logic [fir_pkg::TAP_W-1:0]  wp_r, wp_nxt;
  logic [fir_pkg::CNT_W-1:0]  fill_r, fill_nxt;
  logic [fir_pkg::CNT_W-1:0]  tap_count_r;
  logic                       rd_v_r, rd_last_r;
  logic                       out_tvalid_r;
  logic [fir_pkg::OUT_W-1:0]  out_data_r;

  logic [fir_pkg::CNT_W-1:0]  t_use;
  logic                       accept;
  logic                       issue;
  logic                       last_issue;
  logic                       out_load;
  logic                       mac_done;
  logic signed [fir_pkg::OUT_W-1:0]    mac_acc;
  logic signed [fir_pkg::SAMPLE_W-1:0] hist_rd;
  logic signed [fir_pkg::COEF_W-1:0]   coef_rd;
  logic [fir_pkg::CIDX_W-1:0]          in_coef_index;
  fir_pkg::fir_mem_req_t mem_req;
  fir_pkg::fir_mac_ctl_t mac_ctl;

  assign in_coef_index = in_tdata[CIDX_LO +: fir_pkg::CIDX_W];

  always_comb begin
    t_use = tap_count_r;
    if (tap_count_r == '0) begin
      t_use = fir_pkg::CNT_W'(1);
    end else if (tap_count_r > fir_pkg::TAPS_CNT) begin
      t_use = fir_pkg::TAPS_CNT;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid & in_tready;
  assign issue      = (state_r == S_RUN);
  assign last_issue = (fir_pkg::CNT_W'(k_r) == fir_pkg::CNT_W'(t_use - fir_pkg::CNT_W'(1)));
  assign out_load   = (state_r == S_DONE) & (~out_tvalid_r | out_tready);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    base_nxt  = base_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_tuser == fir_pkg::ACT_SAMPLE) begin
          wp_nxt   = wp_r + fir_pkg::TAP_W'(1);
          base_nxt = wp_r;
          k_nxt    = '0;
          if (fill_r != fir_pkg::FILL_MAX) begin
            fill_nxt = fill_r + fir_pkg::CNT_W'(1);
          end
          if (fill_nxt >= t_use) begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        k_nxt = k_r + fir_pkg::TAP_W'(1);
        if (last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (mac_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      k_r          <= '0;
      base_r       <= '0;
      wp_r         <= '0;
      fill_r       <= '0;
      tap_count_r  <= fir_pkg::TAP_COUNT_RST;
      rd_v_r       <= 1'b0;
      rd_last_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      base_r    <= base_nxt;
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
      rd_v_r    <= issue;
      rd_last_r <= issue & last_issue;
      if (cfg_wr_en) begin
        tap_count_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= mac_acc;
    end
  end

  always_comb begin
    mem_req.hist_we    = accept & (in_tuser == fir_pkg::ACT_SAMPLE);
    mem_req.hist_waddr = wp_r;
    mem_req.hist_wdata = in_tdata[SMP_LO +: fir_pkg::SAMPLE_W];
    mem_req.coef_we    = accept & (in_tuser == fir_pkg::ACT_LOAD)
                         & (fir_pkg::CNT_W'(in_coef_index) < fir_pkg::TAPS_CNT);
    mem_req.coef_waddr = in_coef_index[fir_pkg::TAP_W-1:0];
    mem_req.coef_wdata = in_tdata[COEF_LO +: fir_pkg::COEF_W];
    mem_req.hist_raddr = base_r - k_r;
    mem_req.coef_raddr = k_r;
  end

  always_comb begin
    mac_ctl.clr   = accept;
    mac_ctl.valid = rd_v_r;
    mac_ctl.last  = rd_last_r;
  end

  fir_tap_mem u_mem (
    .clk       (clk),
    .req       (mem_req),
    .hist_rd_r (hist_rd),
    .coef_rd_r (coef_rd)
  );

  fir_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .hist_d (hist_rd),
    .coef_d (coef_rd),
    .acc_r  (mac_acc),
    .done_r (mac_done)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = fir_pkg::OUT_DW'(out_data_r);

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == S_DRAIN)
    else $error("accumulator finished outside drain");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result presented without a finished sum");

  a_wp_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == fir_pkg::ACT_SAMPLE) |=> wp_r == $past(wp_r) + fir_pkg::TAP_W'(1))
    else $error("history pointer did not advance on sample");

  a_no_issue_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> !rd_v_r || $past(rd_v_r))
    else $error("tap read issued after last tap");

endmodule
